### sv/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers shared by the RTL; empty when SYNTHESIS is set.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define PLMX_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("property violated");
`define PLMX_ASSERT_NEVER(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("forbidden condition seen");
`else
`define PLMX_ASSERT(lbl, clk, rst_n, prop)
`define PLMX_ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif
`endif

### sv/plmx_pkg.sv
// ---------------------------------------------------------------------------
// Pooled list package
// Types and codes shared by the pooled list modules.
// ---------------------------------------------------------------------------
package plmx_pkg;

  localparam int KEY_W = 32;
  localparam int IDX_W = 6;

  typedef enum logic [1:0] {
    ACT_INSERT  = 2'd0,
    ACT_EXTRACT = 2'd1,
    ACT_DELETE  = 2'd2,
    ACT_NONE    = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_ABSENT = 2'd3
  } status_t;

  typedef enum logic {
    CMP_LT = 1'b0,
    CMP_EQ = 1'b1
  } cmp_mode_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_INS,
    S_WALK,
    S_UNLINK,
    S_FREE,
    S_RESULT
  } state_t;

  typedef struct packed {
    status_t                  status;
    logic [IDX_W-1:0]         cell_idx;
    logic signed [KEY_W-1:0]  key;
  } res_t;

endpackage

### sv/pooled_list_with_min_extract_core.sv
// ---------------------------------------------------------------------------
// Pooled list with minimum extraction
// Linked list of signed keys in a fixed cell pool, with a free list.
// ---------------------------------------------------------------------------
// Each request on the in_ channel carries an action (insert, extract minimum,
// delete by cell index), a key and an index, and produces exactly one reply
// on the out_ channel with a status, a cell index and a key.
// The block takes one request at a time: in_stall is high from acceptance
// until the reply has been handed to the output register.
// Insert passes through S_INS to S_RESULT, where the reply is offered.
// Extract and delete walk the list one cell per cycle through the registered
// read port of the cell memories; this walk sets the throughput.
// Requests that end at once (full pool, empty list, unused action) go
// straight to S_RESULT. After reset the block builds the free list over all
// POOL_CELLS cells in S_CLEAR and holds in_stall high meanwhile.
// The reply waits in an output register while out_stall is high, and the
// next request may be accepted and worked on during that time.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module pooled_list_with_min_extract_core
  import plmx_pkg::*;
#(
  parameter int POOL_CELLS = 64
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [1:0]              in_action,
  input  logic signed [KEY_W-1:0] in_key,
  input  logic [IDX_W-1:0]        in_index,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [1:0]              out_status,
  output logic [IDX_W-1:0]        out_cell_index,
  output logic signed [KEY_W-1:0] out_key_out
);

  localparam int AW = $clog2(POOL_CELLS);
  localparam int LW = $clog2(POOL_CELLS + 1);

  logic          seq_idle;
  logic          res_valid;
  res_t          res;
  logic          res_ok;
  logic [AW-1:0] rd_addr;
  logic [KEY_W-1:0] key_rd;
  logic [LW-1:0] link_rd;
  logic          key_we;
  logic [AW-1:0] key_waddr;
  logic [KEY_W-1:0] key_wdata;
  logic          link_we;
  logic [AW-1:0] link_waddr;
  logic [LW-1:0] link_wdata;

  logic out_valid_r, out_valid_nxt;
  res_t out_res_r, out_res_nxt;

  plmx_store #(.POOL_CELLS(POOL_CELLS)) u_store (
    .clk        (clk),
    .rd_addr    (rd_addr),
    .key_rd     (key_rd),
    .link_rd    (link_rd),
    .key_we     (key_we),
    .key_waddr  (key_waddr),
    .key_wdata  (key_wdata),
    .link_we    (link_we),
    .link_waddr (link_waddr),
    .link_wdata (link_wdata)
  );

  plmx_seq #(.POOL_CELLS(POOL_CELLS)) u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_action  (in_action),
    .in_key     (in_key),
    .in_index   (in_index),
    .idle       (seq_idle),
    .res_valid  (res_valid),
    .res        (res),
    .res_ok     (res_ok),
    .rd_addr    (rd_addr),
    .key_rd     (key_rd),
    .link_rd    (link_rd),
    .key_we     (key_we),
    .key_waddr  (key_waddr),
    .key_wdata  (key_wdata),
    .link_we    (link_we),
    .link_waddr (link_waddr),
    .link_wdata (link_wdata)
  );

  assign in_stall = !seq_idle;
  assign res_ok   = !out_valid_r || !out_stall;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_res_nxt   = out_res_r;
    if (res_valid && res_ok) begin
      out_valid_nxt = 1'b1;
      out_res_nxt   = res;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r <= out_res_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_res_r.status;
  assign out_cell_index = out_res_r.cell_idx;
  assign out_key_out    = out_res_r.key;

  `PLMX_ASSERT(a_busy_after_accept, clk, rst_n, (in_valid && !in_stall) |=> in_stall)
  `PLMX_ASSERT_NEVER(a_idle_no_reply, clk, rst_n, !in_stall && res_valid)
  `PLMX_ASSERT(a_reply_held, clk, rst_n, (res_valid && !res_ok) |=> res_valid)

endmodule

### sv/plmx_cmp.sv
// ---------------------------------------------------------------------------
// Pooled list comparator
// Shared compare unit: signed less-than for keys, equality for cell numbers.
// ---------------------------------------------------------------------------
module plmx_cmp
  import plmx_pkg::*;
(
  input  cmp_mode_t               mode,
  input  logic signed [KEY_W-1:0] a,
  input  logic signed [KEY_W-1:0] b,
  output logic                    hit
);

  always_comb begin
    case (mode)
      CMP_LT:  hit = (a < b);
      CMP_EQ:  hit = (a == b);
      default: hit = 1'b0;
    endcase
  end

endmodule

### sv/plmx_store.sv
// ---------------------------------------------------------------------------
// Pooled list cell store
// Key and link memories with one write port each and a shared registered read.
// ---------------------------------------------------------------------------
module plmx_store
  import plmx_pkg::*;
#(
  parameter int POOL_CELLS = 64
) (
  input  logic                           clk,
  input  logic [$clog2(POOL_CELLS)-1:0]  rd_addr,
  output logic [KEY_W-1:0]               key_rd,
  output logic [$clog2(POOL_CELLS+1)-1:0] link_rd,
  input  logic                           key_we,
  input  logic [$clog2(POOL_CELLS)-1:0]  key_waddr,
  input  logic [KEY_W-1:0]               key_wdata,
  input  logic                           link_we,
  input  logic [$clog2(POOL_CELLS)-1:0]  link_waddr,
  input  logic [$clog2(POOL_CELLS+1)-1:0] link_wdata
);

  localparam int LW = $clog2(POOL_CELLS + 1);

  logic [KEY_W-1:0] key_mem  [POOL_CELLS];
  logic [LW-1:0]    link_mem [POOL_CELLS];
  logic [KEY_W-1:0] key_rd_r;
  logic [LW-1:0]    link_rd_r;

  always_ff @(posedge clk) begin
    if (key_we) begin
      key_mem[key_waddr] <= key_wdata;
    end
    if (link_we) begin
      link_mem[link_waddr] <= link_wdata;
    end
    key_rd_r  <= key_mem[rd_addr];
    link_rd_r <= link_mem[rd_addr];
  end

  assign key_rd  = key_rd_r;
  assign link_rd = link_rd_r;

endmodule

### sv/plmx_seq.sv
// ---------------------------------------------------------------------------
// Pooled list sequencer
// Runs insert, list walks and unlinking one state at a time over the cell store.
// ---------------------------------------------------------------------------
module plmx_seq
  import plmx_pkg::*;
#(
  parameter int POOL_CELLS = 64
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic [1:0]                      in_action,
  input  logic signed [KEY_W-1:0]         in_key,
  input  logic [IDX_W-1:0]                in_index,
  output logic                            idle,
  output logic                            res_valid,
  output res_t                            res,
  input  logic                            res_ok,
  output logic [$clog2(POOL_CELLS)-1:0]   rd_addr,
  input  logic [KEY_W-1:0]                key_rd,
  input  logic [$clog2(POOL_CELLS+1)-1:0] link_rd,
  output logic                            key_we,
  output logic [$clog2(POOL_CELLS)-1:0]   key_waddr,
  output logic [KEY_W-1:0]                key_wdata,
  output logic                            link_we,
  output logic [$clog2(POOL_CELLS)-1:0]   link_waddr,
  output logic [$clog2(POOL_CELLS+1)-1:0] link_wdata
);

  localparam int AW = $clog2(POOL_CELLS);
  localparam int LW = $clog2(POOL_CELLS + 1);
  localparam logic [LW-1:0] NIL = LW'(POOL_CELLS);

  state_t                  state_r, state_nxt;
  logic [LW-1:0]           list_head_r, list_head_nxt;
  logic [LW-1:0]           free_head_r, free_head_nxt;
  logic [AW-1:0]           clr_r, clr_nxt;
  action_t                 action_r, action_nxt;
  logic signed [KEY_W-1:0] key_r, key_nxt;
  logic [IDX_W-1:0]        index_r, index_nxt;
  logic [LW-1:0]           cur_r, cur_nxt;
  logic [LW-1:0]           prev_r, prev_nxt;
  logic                    first_r, first_nxt;
  logic [LW-1:0]           best_r, best_nxt;
  logic [LW-1:0]           best_prev_r, best_prev_nxt;
  logic [LW-1:0]           best_next_r, best_next_nxt;
  logic signed [KEY_W-1:0] best_key_r, best_key_nxt;
  res_t                    res_r, res_nxt;

  cmp_mode_t               cmp_mode;
  logic signed [KEY_W-1:0] cmp_a;
  logic signed [KEY_W-1:0] cmp_b;
  logic                    cmp_hit;
  logic                    take;

  plmx_cmp u_cmp (
    .mode (cmp_mode),
    .a    (cmp_a),
    .b    (cmp_b),
    .hit  (cmp_hit)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      list_head_r <= NIL;
      free_head_r <= '0;
      clr_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      list_head_r <= list_head_nxt;
      free_head_r <= free_head_nxt;
      clr_r       <= clr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    action_r    <= action_nxt;
    key_r       <= key_nxt;
    index_r     <= index_nxt;
    cur_r       <= cur_nxt;
    prev_r      <= prev_nxt;
    first_r     <= first_nxt;
    best_r      <= best_nxt;
    best_prev_r <= best_prev_nxt;
    best_next_r <= best_next_nxt;
    best_key_r  <= best_key_nxt;
    res_r       <= res_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    list_head_nxt = list_head_r;
    free_head_nxt = free_head_r;
    clr_nxt       = clr_r;
    action_nxt    = action_r;
    key_nxt       = key_r;
    index_nxt     = index_r;
    cur_nxt       = cur_r;
    prev_nxt      = prev_r;
    first_nxt     = first_r;
    best_nxt      = best_r;
    best_prev_nxt = best_prev_r;
    best_next_nxt = best_next_r;
    best_key_nxt  = best_key_r;
    res_nxt       = res_r;

    idle       = 1'b0;
    res_valid  = 1'b0;
    rd_addr    = cur_r[AW-1:0];
    key_we     = 1'b0;
    key_waddr  = free_head_r[AW-1:0];
    key_wdata  = key_r;
    link_we    = 1'b0;
    link_waddr = best_r[AW-1:0];
    link_wdata = free_head_r;

    if (action_r == ACT_EXTRACT) begin
      cmp_mode = CMP_LT;
      cmp_a    = $signed(key_rd);
      cmp_b    = best_key_r;
    end else begin
      cmp_mode = CMP_EQ;
      cmp_a    = $signed(KEY_W'(cur_r));
      cmp_b    = $signed(KEY_W'(index_r));
    end
    take = (action_r == ACT_EXTRACT) ? (first_r || cmp_hit) : cmp_hit;

    case (state_r)
      S_CLEAR: begin
        link_we    = 1'b1;
        link_waddr = clr_r;
        link_wdata = LW'(clr_r) + LW'(1);
        clr_nxt    = clr_r + AW'(1);
        if (clr_r == AW'(POOL_CELLS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        idle = 1'b1;
        if (action_t'(in_action) == ACT_INSERT) begin
          rd_addr = free_head_r[AW-1:0];
        end else begin
          rd_addr = list_head_r[AW-1:0];
        end
        if (in_valid) begin
          action_nxt = action_t'(in_action);
          key_nxt    = in_key;
          index_nxt  = in_index;
          cur_nxt    = list_head_r;
          prev_nxt   = NIL;
          first_nxt  = 1'b1;
          case (action_t'(in_action))
            ACT_INSERT: begin
              if (free_head_r == NIL) begin
                res_nxt   = '{status: ST_FULL, cell_idx: '0, key: '0};
                state_nxt = S_RESULT;
              end else begin
                state_nxt = S_INS;
              end
            end
            ACT_EXTRACT: begin
              if (list_head_r == NIL) begin
                res_nxt   = '{status: ST_EMPTY, cell_idx: '0, key: '0};
                state_nxt = S_RESULT;
              end else begin
                state_nxt = S_WALK;
              end
            end
            ACT_DELETE: begin
              if (list_head_r == NIL) begin
                res_nxt   = '{status: ST_ABSENT, cell_idx: in_index, key: '0};
                state_nxt = S_RESULT;
              end else begin
                state_nxt = S_WALK;
              end
            end
            default: begin
              res_nxt   = '{status: ST_OK, cell_idx: '0, key: '0};
              state_nxt = S_RESULT;
            end
          endcase
        end
      end
      S_INS: begin
        key_we        = 1'b1;
        key_waddr     = free_head_r[AW-1:0];
        key_wdata     = key_r;
        link_we       = 1'b1;
        link_waddr    = free_head_r[AW-1:0];
        link_wdata    = list_head_r;
        list_head_nxt = free_head_r;
        free_head_nxt = link_rd;
        res_nxt       = '{status: ST_OK, cell_idx: IDX_W'(free_head_r), key: '0};
        state_nxt     = S_RESULT;
      end
      S_WALK: begin
        rd_addr   = link_rd[AW-1:0];
        first_nxt = 1'b0;
        if (take) begin
          best_nxt      = cur_r;
          best_prev_nxt = prev_r;
          best_next_nxt = link_rd;
          best_key_nxt  = $signed(key_rd);
        end
        if (action_r == ACT_DELETE && cmp_hit) begin
          state_nxt = S_UNLINK;
        end else if (link_rd == NIL) begin
          if (action_r == ACT_EXTRACT) begin
            state_nxt = S_UNLINK;
          end else begin
            res_nxt   = '{status: ST_ABSENT, cell_idx: index_r, key: '0};
            state_nxt = S_RESULT;
          end
        end else begin
          cur_nxt  = link_rd;
          prev_nxt = cur_r;
        end
      end
      S_UNLINK: begin
        if (best_prev_r == NIL) begin
          list_head_nxt = best_next_r;
        end else begin
          link_we    = 1'b1;
          link_waddr = best_prev_r[AW-1:0];
          link_wdata = best_next_r;
        end
        state_nxt = S_FREE;
      end
      S_FREE: begin
        link_we       = 1'b1;
        link_waddr    = best_r[AW-1:0];
        link_wdata    = free_head_r;
        free_head_nxt = best_r;
        res_nxt       = '{status: ST_OK, cell_idx: IDX_W'(best_r), key: best_key_r};
        state_nxt     = S_RESULT;
      end
      S_RESULT: begin
        res_valid = 1'b1;
        if (res_ok) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign res = res_r;

endmodule

### tb/tb_top.sv
// ---------------------------------------------------------------------------
// Testbench for the pooled list with minimum extraction
// Requests go in through a short table of directed cases, then about 1800
// random ones in bursts that fill, drain or mix the pool. A local model of the
// cell pool predicts replies the table leaves open; each reply is compared
// field by field with the oldest expectation. Both sides idle at random, with
// one quiet stretch and one long receiver hold-off that backs up the input.
// ---------------------------------------------------------------------------
module tb_top;
  import plmx_pkg::*;

  localparam int POOL_CELLS = 64;
  localparam int RANDOM_REQUESTS = 1800;
  localparam int DIRECTED_ROWS = 24;

  typedef logic [IDX_W:0] link_t;
  localparam link_t NIL = link_t'(POOL_CELLS);

  localparam logic signed [KEY_W-1:0] KEY_MIN = 32'sh8000_0000;
  localparam logic signed [KEY_W-1:0] KEY_MAX = 32'sh7fff_ffff;

  typedef struct {
    action_t                 act;
    logic signed [KEY_W-1:0] key;
    logic [IDX_W-1:0]        idx;
    bit                      typed;
    res_t                    reply;
  } stim_row_t;

  logic                    clk = 1'b0;
  logic                    rst_n;
  logic                    in_valid;
  logic                    in_stall;
  logic [1:0]              in_action;
  logic signed [KEY_W-1:0] in_key;
  logic [IDX_W-1:0]        in_index;
  logic                    out_valid;
  logic                    out_stall;
  logic [1:0]              out_status;
  logic [IDX_W-1:0]        out_cell_index;
  logic signed [KEY_W-1:0] out_key_out;

  logic signed [KEY_W-1:0] pool_key [POOL_CELLS];
  link_t                   pool_link [POOL_CELLS];
  link_t                   chain_head;
  link_t                   spare_head;

  res_t replies_due [$];
  res_t reply_due;
  int   mismatch_count = 0;
  int   accepted_count = 0;
  bit   quiet_stretch = 1'b0;

  stim_row_t directed_rows [DIRECTED_ROWS] = '{
    '{ACT_EXTRACT, 32'sd0,   6'd0,  1'b1, '{ST_EMPTY,  6'd0,  32'sd0}},
    '{ACT_DELETE,  32'sd0,   6'd0,  1'b1, '{ST_ABSENT, 6'd0,  32'sd0}},
    '{ACT_DELETE,  32'sd0,   6'd63, 1'b1, '{ST_ABSENT, 6'd63, 32'sd0}},
    '{ACT_NONE,    -32'sd1,  6'd63, 1'b1, '{ST_OK,     6'd0,  32'sd0}},
    '{ACT_INSERT,  KEY_MAX,  6'd0,  1'b1, '{ST_OK,     6'd0,  32'sd0}},
    '{ACT_INSERT,  KEY_MIN,  6'd63, 1'b1, '{ST_OK,     6'd1,  32'sd0}},
    '{ACT_INSERT,  32'sd0,   6'd0,  1'b1, '{ST_OK,     6'd2,  32'sd0}},
    '{ACT_INSERT,  -32'sd1,  6'd0,  1'b1, '{ST_OK,     6'd3,  32'sd0}},
    '{ACT_INSERT,  -32'sd1,  6'd0,  1'b1, '{ST_OK,     6'd4,  32'sd0}},
    '{ACT_EXTRACT, 32'sd0,   6'd0,  1'b1, '{ST_OK,     6'd1,  KEY_MIN}},
    '{ACT_EXTRACT, 32'sd0,   6'd0,  1'b0, '{ST_OK,     6'd0,  32'sd0}},
    '{ACT_EXTRACT, 32'sd0,   6'd0,  1'b0, '{ST_OK,     6'd0,  32'sd0}},
    '{ACT_DELETE,  32'sd0,   6'd0,  1'b0, '{ST_OK,     6'd0,  32'sd0}},
    '{ACT_DELETE,  32'sd0,   6'd0,  1'b1, '{ST_ABSENT, 6'd0,  32'sd0}},
    '{ACT_INSERT,  32'sd5,   6'd0,  1'b0, '{ST_OK,     6'd0,  32'sd0}},
    '{ACT_INSERT,  32'sd5,   6'd0,  1'b0, '{ST_OK,     6'd0,  32'sd0}},
    '{ACT_INSERT,  32'sd3,   6'd0,  1'b0, '{ST_OK,     6'd0,  32'sd0}},
    '{ACT_DELETE,  32'sd0,   6'd2,  1'b0, '{ST_OK,     6'd0,  32'sd0}},
    '{ACT_EXTRACT, 32'sd0,   6'd0,  1'b0, '{ST_OK,     6'd0,  32'sd0}},
    '{ACT_EXTRACT, 32'sd0,   6'd0,  1'b0, '{ST_OK,     6'd0,  32'sd0}},
    '{ACT_EXTRACT, 32'sd0,   6'd0,  1'b0, '{ST_OK,     6'd0,  32'sd0}},
    '{ACT_EXTRACT, 32'sd0,   6'd0,  1'b1, '{ST_EMPTY,  6'd0,  32'sd0}},
    '{ACT_DELETE,  32'sd0,   6'd40, 1'b1, '{ST_ABSENT, 6'd40, 32'sd0}},
    '{ACT_NONE,    32'sd0,   6'd0,  1'b1, '{ST_OK,     6'd0,  32'sd0}}
  };

  pooled_list_with_min_extract_core #(
    .POOL_CELLS(POOL_CELLS)
  ) dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_action     (in_action),
    .in_key        (in_key),
    .in_index      (in_index),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_status    (out_status),
    .out_cell_index(out_cell_index),
    .out_key_out   (out_key_out)
  );

  always #5 clk = ~clk;

  function automatic void clear_pool();
    for (int i = 0; i < POOL_CELLS; i++) begin
      pool_key[i] = '0;
      pool_link[i] = link_t'(i + 1);
    end
    chain_head = NIL;
    spare_head = '0;
  endfunction

  function automatic void release_cell(link_t c, link_t p);
    if (p == NIL) begin
      chain_head = pool_link[c[IDX_W-1:0]];
    end else begin
      pool_link[p[IDX_W-1:0]] = pool_link[c[IDX_W-1:0]];
    end
    pool_link[c[IDX_W-1:0]] = spare_head;
    spare_head = c;
  endfunction

  function automatic res_t apply_request(action_t act, logic signed [KEY_W-1:0] k,
                                         logic [IDX_W-1:0] idx);
    res_t  r;
    link_t cur;
    link_t prev;
    link_t best;
    link_t best_prev;
    int    steps;
    r = '0;
    r.status = ST_OK;
    case (act)
      ACT_INSERT: begin
        if (spare_head == NIL) begin
          r.status = ST_FULL;
        end else begin
          cur = spare_head;
          spare_head = pool_link[cur[IDX_W-1:0]];
          pool_key[cur[IDX_W-1:0]] = k;
          pool_link[cur[IDX_W-1:0]] = chain_head;
          chain_head = cur;
          r.cell_idx = cur[IDX_W-1:0];
        end
      end
      ACT_EXTRACT: begin
        if (chain_head == NIL) begin
          r.status = ST_EMPTY;
        end else begin
          best = chain_head;
          best_prev = NIL;
          prev = chain_head;
          cur = pool_link[chain_head[IDX_W-1:0]];
          steps = 1;
          while (cur != NIL && steps < POOL_CELLS) begin
            if (pool_key[cur[IDX_W-1:0]] < pool_key[best[IDX_W-1:0]]) begin
              best = cur;
              best_prev = prev;
            end
            prev = cur;
            cur = pool_link[cur[IDX_W-1:0]];
            steps++;
          end
          r.cell_idx = best[IDX_W-1:0];
          r.key = pool_key[best[IDX_W-1:0]];
          release_cell(best, best_prev);
        end
      end
      ACT_DELETE: begin
        r.status = ST_ABSENT;
        r.cell_idx = idx;
        prev = NIL;
        cur = chain_head;
        steps = 0;
        while (cur != NIL && steps < POOL_CELLS && r.status == ST_ABSENT) begin
          if (cur == {1'b0, idx}) begin
            r.status = ST_OK;
            r.key = pool_key[cur[IDX_W-1:0]];
            release_cell(cur, prev);
          end else begin
            prev = cur;
            cur = pool_link[cur[IDX_W-1:0]];
          end
          steps++;
        end
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  function automatic logic [IDX_W-1:0] pick_listed_cell();
    logic [IDX_W-1:0] cells [$];
    link_t            walk;
    walk = chain_head;
    while (walk != NIL && cells.size() < POOL_CELLS) begin
      cells.push_back(walk[IDX_W-1:0]);
      walk = pool_link[walk[IDX_W-1:0]];
    end
    if (cells.size() == 0) begin
      return IDX_W'($urandom);
    end
    return cells[$urandom_range(0, cells.size() - 1)];
  endfunction

  function automatic logic signed [KEY_W-1:0] random_key();
    int draw;
    draw = $urandom_range(0, 99);
    if (draw < 40) begin
      return KEY_W'(int'($urandom_range(0, 15)) - 8);
    end else if (draw < 50) begin
      case ($urandom_range(0, 3))
        0: return KEY_MIN;
        1: return KEY_MAX;
        2: return -32'sd1;
        default: return 32'sd0;
      endcase
    end
    return $urandom;
  endfunction

  task automatic issue_request(input action_t act, input logic signed [KEY_W-1:0] k,
                               input logic [IDX_W-1:0] idx, output res_t predicted);
    if (!quiet_stretch) begin
      while ($urandom_range(0, 99) < 10) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    in_action <= act;
    in_key <= k;
    in_index <= idx;
    do @(posedge clk); while (in_stall);
    predicted = apply_request(act, k, idx);
    accepted_count++;
  endtask

  initial begin : stimulus
    res_t                    predicted;
    action_t                 act;
    logic signed [KEY_W-1:0] k;
    logic [IDX_W-1:0]        idx;
    int                      mode;
    int                      burst_left;
    int                      insert_share;
    int                      draw;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_action <= ACT_NONE;
    in_key <= '0;
    in_index <= '0;
    clear_pool();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      issue_request(directed_rows[i].act, directed_rows[i].key, directed_rows[i].idx,
                    predicted);
      replies_due.push_back(directed_rows[i].typed ? directed_rows[i].reply : predicted);
    end

    burst_left = 0;
    mode = 0;
    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      if (burst_left == 0) begin
        mode = $urandom_range(0, 2);
        burst_left = $urandom_range(40, 150);
      end
      burst_left--;
      quiet_stretch = (n >= 900 && n < 1200);
      insert_share = (mode == 0) ? 80 : (mode == 1) ? 20 : 50;
      draw = $urandom_range(0, 99);
      if (draw < 2) begin
        act = ACT_NONE;
      end else if (draw < insert_share) begin
        act = ACT_INSERT;
      end else begin
        act = $urandom_range(0, 1) ? ACT_EXTRACT : ACT_DELETE;
      end
      k = random_key();
      idx = ($urandom_range(0, 99) < 85) ? pick_listed_cell() : IDX_W'($urandom);
      issue_request(act, k, idx, predicted);
      replies_due.push_back(predicted);
    end
    in_valid <= 1'b0;
    quiet_stretch = 1'b0;

    while (replies_due.size() != 0) @(posedge clk);
    repeat (POOL_CELLS + 10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("PASS pooled_list_with_min_extract_core");
    end else begin
      $display("FAIL pooled_list_with_min_extract_core");
    end
    $finish;
  end

  initial begin : receiver
    bit backlog_done;
    backlog_done = 1'b0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (!backlog_done && accepted_count >= 300) begin
        backlog_done = 1'b1;
        repeat (400) begin
          out_stall <= 1'b1;
          @(posedge clk);
        end
      end
      out_stall <= !quiet_stretch && ($urandom_range(0, 99) < 10);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (replies_due.size() == 0) begin
        $error("reply with no request outstanding: status %0d cell %0d key %0d",
               out_status, out_cell_index, out_key_out);
        mismatch_count++;
      end else begin
        reply_due = replies_due.pop_front();
        if (out_status !== reply_due.status) begin
          $error("status: expected %0d, got %0d", reply_due.status, out_status);
          mismatch_count++;
        end
        if (out_cell_index !== reply_due.cell_idx) begin
          $error("cell_index: expected %0d, got %0d", reply_due.cell_idx, out_cell_index);
          mismatch_count++;
        end
        if (out_key_out !== reply_due.key) begin
          $error("key_out: expected %0d, got %0d", reply_due.key, out_key_out);
          mismatch_count++;
        end
      end
    end
  end

  initial begin : watchdog
    #10_000_000;
    $display("FAIL pooled_list_with_min_extract_core");
    $finish;
  end

endmodule
